// ===== sv/local_histogram_equalizer_top_assert.svh =====
// Assertion macros for the local histogram equalizer.
// Included by RTL files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef LOCAL_HISTOGRAM_EQUALIZER_TOP_ASSERT_SVH
`define LOCAL_HISTOGRAM_EQUALIZER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LHE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lhe assertion failed");
// next-cycle implication
`define LHE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lhe assertion failed");
`else
`define LHE_ASSERT_IMP(lbl, ante, cons)
`define LHE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/lhe_pkg.sv =====
// Shared types and constants for the local histogram equalizer.
// No dependencies; used by lhe_div, lhe_ctrl and the top level.
package lhe_pkg;

	localparam int CRD_W      = 13;  // signed coordinate math, covers 2*size
	localparam int HGT_W      = 9;
	localparam int WIN_W      = 4;
	localparam int SPAN_W     = 4;   // 2*half window, at most 14
	localparam int CNT_W      = 8;
	localparam int NUM_W      = 24;  // 255*256*count
	localparam int DEN_W      = 8;   // m*n
	localparam int EQ_W       = 18;
	localparam int FLD_W      = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_PAD_W  = OUT_DATA_W - EQ_W - CNT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// 255*256 = 2^16 - 2^8
	localparam int SCALE_HI_SH = 16;
	localparam int SCALE_LO_SH = 8;

	localparam logic [HGT_W-1:0] HGT_RST = 9'd256;
	localparam logic [WIN_W-1:0] WIN_RST = 4'd3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS  = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [HGT_W-1:0] image_height;
		logic [HGT_W-1:0] image_width;
		logic [WIN_W-1:0] window_rows;
		logic [WIN_W-1:0] window_cols;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== sv/lhe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lhe_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lhe_pkg (request/response structs, widths).
module lhe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lhe_pkg::div_req_t req,
	output lhe_pkg::div_rsp_t rsp
);

	localparam int NW = lhe_pkg::NUM_W;
	localparam int DW = lhe_pkg::DEN_W;
	localparam int SW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          qbit;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign qbit    = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			// remainder stays below den, so DW bits hold it
			rem_q  <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quot_q <= {quot_q[NW-2:0], qbit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== sv/lhe_ctrl.sv =====
// Sequencer: pixel writes, window walk through the mirror/address unit,
// rank counting, divider hand-off and output register.
// Depends on lhe_pkg and local_histogram_equalizer_top_assert.svh.
`include "local_histogram_equalizer_top_assert.svh"

module lhe_ctrl #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int MAX_WINDOW = 15,
	parameter int LEVELS     = 256,
	parameter int PIX_W      = 8,
	parameter int ADDR_W     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lhe_pkg::cfg_t                     cfg,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lhe_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lhe_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              ram_we,
	output logic [ADDR_W-1:0]                 ram_waddr,
	output logic [PIX_W-1:0]                  ram_wdata,
	output logic [ADDR_W-1:0]                 ram_raddr,
	input  logic [PIX_W-1:0]                  ram_rdata,
	output lhe_pkg::div_req_t                 div_req,
	input  lhe_pkg::div_rsp_t                 div_rsp
);

	localparam int CW  = lhe_pkg::CRD_W;
	localparam int FW  = lhe_pkg::FLD_W;
	localparam int WW  = lhe_pkg::WIN_W;
	localparam int PW  = lhe_pkg::SPAN_W;
	localparam int NW  = lhe_pkg::NUM_W;
	localparam int DW  = lhe_pkg::DEN_W;
	localparam int KW  = lhe_pkg::CNT_W;
	localparam int EW  = lhe_pkg::EQ_W;

	localparam logic signed [CW-1:0] S_ONE = CW'(1);
	localparam logic signed [CW-1:0] S_TWO = CW'(2);

	// reflect about the edge without repeating it, then clamp
	function automatic logic signed [CW-1:0] mirror(input logic signed [CW-1:0] p,
			input logic signed [CW-1:0] size);
		logic signed [CW-1:0] q;
		q = p;
		if (q[CW-1]) begin
			q = -q;
		end else if (q >= size) begin
			q = size + size - S_TWO - q;
		end
		if (q[CW-1]) begin
			q = '0;
		end
		if (q >= size) begin
			q = size - S_ONE;
		end
		return q;
	endfunction

	lhe_pkg::state_t state_q, state_d;

	logic [FW-1:0] in_row, in_col, in_val;
	logic          accept;
	logic          center_issue, walk_issue, div_start, out_load;

	// clamped config, sampled on a query beat
	logic [CW-1:0] h_c, w_c, x_c, y_c;
	logic [WW-1:0] m_c, n_c;
	logic [DW-1:0] den_c;

	logic signed [CW-1:0] h_q, w_q, x_q, y_q;
	logic [WW-1:0]        a_q, b_q;
	logic [PW-1:0]        span_r_q, span_c_q, i_q, j_q;
	logic [DW-1:0]        den_q;

	logic signed [CW-1:0] row_p, col_p, row_m, col_m;

	logic          tap_vld_s1, ctr_s1;
	logic [CW-1:0] tx_s1, ty_s1;
	logic          rd_vld_s2, ctr_s2;

	logic [PIX_W-1:0] center_q;
	logic [KW-1:0]    count_q;

	logic          out_valid_q;
	logic [EW-1:0] out_eq_q;
	logic [KW-1:0] out_cnt_q;

	assign in_row = s_tdata[FW-1:0];
	assign in_col = s_tdata[2*FW-1:FW];
	assign in_val = s_tdata[3*FW-1:2*FW];
	assign accept = s_tvalid && s_tready;

	// pixel write goes straight to the store
	always_comb begin
		ram_we    = accept && (s_tuser == lhe_pkg::CMD_WRITE)
			&& (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
		ram_waddr = ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col);
		if (32'(in_val) > LEVELS - 1) begin
			ram_wdata = PIX_W'(LEVELS - 1);
		end else begin
			ram_wdata = PIX_W'(in_val);
		end
	end

	always_comb begin
		if (cfg.image_height == '0) begin
			h_c = CW'(1);
		end else if (32'(cfg.image_height) > MAX_ROWS) begin
			h_c = CW'(MAX_ROWS);
		end else begin
			h_c = CW'(cfg.image_height);
		end
		if (cfg.image_width == '0) begin
			w_c = CW'(1);
		end else if (32'(cfg.image_width) > MAX_COLS) begin
			w_c = CW'(MAX_COLS);
		end else begin
			w_c = CW'(cfg.image_width);
		end
		if (cfg.window_rows == '0) begin
			m_c = WW'(1);
		end else if (32'(cfg.window_rows) > MAX_WINDOW) begin
			m_c = WW'(MAX_WINDOW);
		end else begin
			m_c = cfg.window_rows;
		end
		if (cfg.window_cols == '0) begin
			n_c = WW'(1);
		end else if (32'(cfg.window_cols) > MAX_WINDOW) begin
			n_c = WW'(MAX_WINDOW);
		end else begin
			n_c = cfg.window_cols;
		end
		x_c   = (CW'(in_row) < h_c) ? CW'(in_row) : h_c - CW'(1);
		y_c   = (CW'(in_col) < w_c) ? CW'(in_col) : w_c - CW'(1);
		den_c = DW'(m_c) * DW'(n_c);
	end

	// shared mirror unit: one tap coordinate pair per cycle
	always_comb begin
		row_p = x_q - $signed(CW'(a_q)) + $signed(CW'(i_q));
		col_p = y_q - $signed(CW'(b_q)) + $signed(CW'(j_q));
		row_m = mirror(row_p, h_q);
		col_m = mirror(col_p, w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		center_issue = 1'b0;
		walk_issue   = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		s_tready     = 1'b0;
		unique case (state_q)
			lhe_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == lhe_pkg::CMD_QUERY)) begin
					state_d = lhe_pkg::ST_CENTER;
				end
			end
			lhe_pkg::ST_CENTER: begin
				center_issue = 1'b1;
				state_d      = lhe_pkg::ST_WALK;
			end
			lhe_pkg::ST_WALK: begin
				walk_issue = 1'b1;
				if ((i_q == span_r_q) && (j_q == span_c_q)) begin
					state_d = lhe_pkg::ST_DRAIN;
				end
			end
			lhe_pkg::ST_DRAIN: begin
				if (!tap_vld_s1 && !rd_vld_s2) begin
					div_start = 1'b1;
					state_d   = lhe_pkg::ST_DIV;
				end
			end
			lhe_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = lhe_pkg::ST_DONE;
				end
			end
			lhe_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = lhe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhe_pkg::ST_IDLE;
			end
		endcase
	end

	// query context
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == lhe_pkg::CMD_QUERY)) begin
			h_q      <= h_c;
			w_q      <= w_c;
			x_q      <= x_c;
			y_q      <= y_c;
			a_q      <= m_c >> 1;
			b_q      <= n_c >> 1;
			span_r_q <= PW'(m_c >> 1) << 1;
			span_c_q <= PW'(n_c >> 1) << 1;
			den_q    <= den_c;
			i_q      <= '0;
			j_q      <= '0;
		end else if (walk_issue) begin
			if (j_q == span_c_q) begin
				j_q <= '0;
				i_q <= i_q + PW'(1);
			end else begin
				j_q <= j_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_s1 <= 1'b0;
			rd_vld_s2  <= 1'b0;
		end else begin
			tap_vld_s1 <= center_issue || walk_issue;
			rd_vld_s2  <= tap_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (center_issue) begin
			ctr_s1 <= 1'b1;
			tx_s1  <= x_q;
			ty_s1  <= y_q;
		end else begin
			ctr_s1 <= 1'b0;
			tx_s1  <= row_m;
			ty_s1  <= col_m;
		end
		ctr_s2 <= ctr_s1;
	end

	assign ram_raddr = ADDR_W'(tx_s1) * ADDR_W'(MAX_COLS) + ADDR_W'(ty_s1);

	// center read lands in the cycle before the first tap compare
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == lhe_pkg::CMD_QUERY)) begin
			count_q <= '0;
		end else if (rd_vld_s2) begin
			if (ctr_s2) begin
				center_q <= ram_rdata;
			end else if (ram_rdata <= center_q) begin
				count_q <= count_q + KW'(1);
			end
		end
	end

	assign div_req.start = div_start;
	assign div_req.num   = (NW'(count_q) << lhe_pkg::SCALE_HI_SH)
		- (NW'(count_q) << lhe_pkg::SCALE_LO_SH);
	assign div_req.den   = den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_eq_q  <= div_rsp.quot[EW-1:0];
			out_cnt_q <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{lhe_pkg::OUT_PAD_W{1'b0}}, out_cnt_q, out_eq_q};

	`LHE_ASSERT_IMP(a_idle_pipe_empty, s_tready, !tap_vld_s1 && !rd_vld_s2)
	`LHE_ASSERT_IMP(a_div_start_drained, div_req.start, !tap_vld_s1 && !rd_vld_s2 && !div_rsp.busy)
	`LHE_ASSERT_NXT(a_center_first, state_q == lhe_pkg::ST_CENTER, tap_vld_s1 && ctr_s1)
	`LHE_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == lhe_pkg::ST_DIV)

endmodule

// ===== sv/local_histogram_equalizer_top.sv =====
// Local histogram equalizer, top level: config registers, pixel store,
// sequencer and divider. Depends on lhe_pkg, lhe_ram, lhe_div, lhe_ctrl.
//
//  channel  | signals                          | beat holds
//  ---------+----------------------------------+---------------------------------
//  cfg      | cfg_we cfg_index cfg_data        | register write, no back-pressure
//  s (in)   | s_tvalid s_tready s_tdata s_tuser| command + pixel row/col/value
//  m (out)  | m_tvalid m_tready m_tdata        | equalized value + rank count
//
// The window tap count W is (2*(rows/2)+1)*(2*(cols/2)+1), so 225 at 15x15;
// the taps go one per cycle through the single store read port, then a
// bit-serial divide runs. s_tready is low for the whole query; a finished
// result waits in the output register while the next beat is taken, and a
// second query waits before its result load if the first is still untaken.
// Reset clears control only; the pixel store has no clearing pass.
module local_histogram_equalizer_top #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int MAX_WINDOW = 15,
	parameter int LEVELS     = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [lhe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lhe_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lhe_pkg::IN_DATA_W-1:0]       s_tdata,   // pixel_row, pixel_col, pixel_value
	input  logic                                s_tuser,   // command (0 write, 1 query)
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lhe_pkg::OUT_DATA_W-1:0]      m_tdata    // equalized_value, rank_count, pad
);

	// store holds min(value, LEVELS-1), never more than 8 bits
	localparam int PIX_W  = ($clog2(LEVELS) < 8) ? $clog2(LEVELS) : 8;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam int HW = lhe_pkg::HGT_W;
	localparam int WW = lhe_pkg::WIN_W;

	logic [HW-1:0] height_q, width_q;
	logic [WW-1:0] wrows_q, wcols_q;

	lhe_pkg::cfg_t     cfg;
	lhe_pkg::div_req_t div_req;
	lhe_pkg::div_rsp_t div_rsp;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [PIX_W-1:0]  ram_wdata, ram_rdata;

	// config register file, to be written by the user only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= lhe_pkg::HGT_RST;
			width_q  <= lhe_pkg::HGT_RST;
			wrows_q  <= lhe_pkg::WIN_RST;
			wcols_q  <= lhe_pkg::WIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lhe_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				lhe_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				lhe_pkg::REG_WINDOW_ROWS:  wrows_q  <= cfg_data[WW-1:0];
				lhe_pkg::REG_WINDOW_COLS:  wcols_q  <= cfg_data[WW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.image_height = height_q;
	assign cfg.image_width  = width_q;
	assign cfg.window_rows  = wrows_q;
	assign cfg.window_cols  = wcols_q;

	lhe_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lhe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lhe_ctrl #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.MAX_WINDOW (MAX_WINDOW),
		.LEVELS     (LEVELS),
		.PIX_W      (PIX_W),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

endmodule
